>>> rtl/skpl_pkg.sv
// Shared types and constants for the soft-knee peak limiter.
// Used by every module of the block; depends on nothing else.
package skpl_pkg;

    localparam int MAX_CHANNELS = 8;
    localparam int SAMPLE_BITS  = 16;
    localparam int LANE_W       = $clog2(MAX_CHANNELS);
    localparam int COUNT_W      = 4;
    localparam int COEFF_W      = 16;
    localparam int LEVEL_W      = 15;
    localparam int ENV_W        = 16;
    localparam int PEAK_W       = SAMPLE_BITS + 1;
    localparam int GAIN_W       = 16;
    localparam int MUL_W        = 18;
    localparam int PROD_W       = 2 * MUL_W;
    localparam int DIV_NUM_W    = 32;
    localparam int DIV_DEN_W    = 16;
    localparam int DIV_STEPS    = 2;
    localparam int DIV_CNT_W    = $clog2(DIV_DEN_W / DIV_STEPS);
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 16;

    localparam logic [GAIN_W-1:0] GAIN_ONE       = 16'd32768;
    localparam logic [GAIN_W-1:0] GAIN_UNITY_MIN = 16'd32735;

    // Register indexes of the configuration port.
    localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_COUNT = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ATTACK_COEFF  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_RELEASE_COEFF = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_KNEE_START    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_KNEE_WIDTH    = 3'd4;

    // Reset values of the configuration registers.
    localparam logic [COUNT_W-1:0] RST_CHANNEL_COUNT = 4'd2;
    localparam logic [COEFF_W-1:0] RST_ATTACK_COEFF  = 16'd64857;
    localparam logic [COEFF_W-1:0] RST_RELEASE_COEFF = 16'd65508;
    localparam logic [LEVEL_W-1:0] RST_KNEE_START    = 15'd29164;
    localparam logic [LEVEL_W-1:0] RST_KNEE_WIDTH    = 15'd2621;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    typedef struct packed {
        sample_t sample_0;
        sample_t sample_1;
        sample_t sample_2;
        sample_t sample_3;
        sample_t sample_4;
        sample_t sample_5;
        sample_t sample_6;
        sample_t sample_7;
        logic    block_end;
    } in_item_t;

    typedef struct packed {
        sample_t             out_0;
        sample_t             out_1;
        sample_t             out_2;
        sample_t             out_3;
        sample_t             out_4;
        sample_t             out_5;
        sample_t             out_6;
        sample_t             out_7;
        logic [GAIN_W-1:0]   applied_gain;
        logic                block_end_out;
    } out_item_t;

    typedef struct packed {
        logic [COUNT_W-1:0] channel_count;
        logic [COEFF_W-1:0] attack_coeff;
        logic [COEFF_W-1:0] release_coeff;
        logic [LEVEL_W-1:0] knee_start;
        logic [LEVEL_W-1:0] knee_width;
    } cfg_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;
        logic peak_step;
        logic env_mul;
        logic env_update;
        logic knee_mul;
        logic divk_start;
        logic divg_start;
        logic gain_load;
        logic scale_step;
        logic result_load;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic lane_last;
        logic env_over;
        logic div_done;
        logic out_free;
    } dp_sts_t;

endpackage

>>> rtl/soft_knee_peak_limiter.sv
// Top level of the soft-knee peak limiter: configuration registers,
// controller and datapath. Depends on skpl_pkg, skpl_ctrl, skpl_dp.

// The limiter takes one frame of up to eight signed Q1.15 samples per
// request, tracks the frame peak with a one-pole attack/release envelope,
// and returns the frame scaled by a soft-knee gain together with that gain.
// A frame passes the eight-lane peak scan, one lane per cycle, the envelope
// update and the knee test, then the eight-lane scaling pass, one lane per
// cycle on the shared multiplier. When the envelope sits above knee_start,
// two divisions on a shared divider that yields two quotient bits per cycle
// come between the knee test and the scaling pass.
// One frame is processed at a time; the next request is taken as soon as the
// previous frame's result sits in the output register, even if it has not
// yet been taken downstream. If the output register is still occupied when a
// new result is ready, the block waits for it to drain. Configuration should
// only be written while no frame is in flight.
module soft_knee_peak_limiter (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  skpl_pkg::in_item_t                s_payload,
    output logic                              m_valid,
    input  logic                              m_ready,
    output skpl_pkg::out_item_t               m_payload,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [skpl_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [skpl_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import skpl_pkg::*;

    cfg_t       cfg_reg, cfg_next;
    ctrl_cmd_t  cmd;
    dp_sts_t    sts;

    // Configuration writes are always accepted, and an index beyond the
    // register list is accepted and ignored.
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_CHANNEL_COUNT: cfg_next.channel_count = cfg_data[COUNT_W-1:0];
                REG_ATTACK_COEFF:  cfg_next.attack_coeff  = cfg_data[COEFF_W-1:0];
                REG_RELEASE_COEFF: cfg_next.release_coeff = cfg_data[COEFF_W-1:0];
                REG_KNEE_START:    cfg_next.knee_start    = cfg_data[LEVEL_W-1:0];
                REG_KNEE_WIDTH:    cfg_next.knee_width    = cfg_data[LEVEL_W-1:0];
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.channel_count <= RST_CHANNEL_COUNT;
            cfg_reg.attack_coeff  <= RST_ATTACK_COEFF;
            cfg_reg.release_coeff <= RST_RELEASE_COEFF;
            cfg_reg.knee_start    <= RST_KNEE_START;
            cfg_reg.knee_width    <= RST_KNEE_WIDTH;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // The controller owns the input handshake and sequences every step.
    skpl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // The datapath holds the frame, the envelope and the output register.
    skpl_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .cfg       (cfg_reg),
        .s_payload (s_payload),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_payload (m_payload)
    );

`ifndef ASSERT_OFF
    // A reported gain is either unity or strictly below the unity threshold.
    a_gain_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_payload.applied_gain < GAIN_UNITY_MIN) ||
                     (m_payload.applied_gain == GAIN_ONE)))
        else $error("applied_gain lies between the unity threshold and unity");

    // Once a request is taken, no further request is taken in the next cycle.
    a_one_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken while a frame is being processed");

    // A new result only appears from a frame that was in progress.
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result appeared without a frame in progress");
`endif

endmodule

>>> rtl/skpl_div.sv
// Iterative unsigned divider, two quotient bits per cycle.
// Depends on skpl_pkg for widths.
module skpl_div (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [skpl_pkg::DIV_NUM_W-1:0] num,
    input  logic [skpl_pkg::DIV_DEN_W-1:0] den,
    output logic                           done,
    output logic [skpl_pkg::DIV_DEN_W-1:0] quot
);
    import skpl_pkg::*;

    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_DEN_W-1:0] lo_reg, lo_next;
    logic [DIV_DEN_W-1:0] den_reg, den_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;

    // The caller guarantees that the upper half of the numerator is below the
    // divisor, so the quotient fits in the lower half.
    always_comb begin
        logic [DIV_DEN_W:0]   trial;
        logic [DIV_DEN_W-1:0] r;
        logic [DIV_DEN_W-1:0] l;
        logic                 qbit;
        trial     = '0;
        qbit      = 1'b0;
        r         = rem_reg;
        l         = lo_reg;
        rem_next  = rem_reg;
        lo_next   = lo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = num[DIV_NUM_W-1:DIV_DEN_W];
            lo_next   = num[DIV_DEN_W-1:0];
            den_next  = den;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            for (int k = 0; k < DIV_STEPS; k++) begin
                trial = {r, l[DIV_DEN_W-1]};
                if (trial >= {1'b0, den_reg}) begin
                    trial = trial - {1'b0, den_reg};
                    qbit  = 1'b1;
                end else begin
                    qbit  = 1'b0;
                end
                r = trial[DIV_DEN_W-1:0];
                l = {l[DIV_DEN_W-2:0], qbit};
            end
            rem_next = r;
            lo_next  = l;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == {DIV_CNT_W{1'b1}}) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        lo_reg  <= lo_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quot = lo_reg;

endmodule

>>> rtl/skpl_ctrl.sv
// Controller state machine of the peak limiter: sequences the datapath.
// Depends on skpl_pkg for the command and status structs.
module skpl_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  skpl_pkg::dp_sts_t    sts,
    output skpl_pkg::ctrl_cmd_t  cmd
);
    import skpl_pkg::*;

    typedef enum logic [11:0] {
        ST_IDLE     = 12'b0000_0000_0001,
        ST_PEAK     = 12'b0000_0000_0010,
        ST_ENV_MUL  = 12'b0000_0000_0100,
        ST_ENV_UPD  = 12'b0000_0000_1000,
        ST_KNEE     = 12'b0000_0001_0000,
        ST_DIVK_GO  = 12'b0000_0010_0000,
        ST_DIVK_RUN = 12'b0000_0100_0000,
        ST_DIVG_GO  = 12'b0000_1000_0000,
        ST_DIVG_RUN = 12'b0001_0000_0000,
        ST_GAIN     = 12'b0010_0000_0000,
        ST_SCALE    = 12'b0100_0000_0000,
        ST_WRITE    = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_PEAK;
                end
            end
            ST_PEAK: begin
                cmd.peak_step = 1'b1;
                if (sts.lane_last) begin
                    state_next = ST_ENV_MUL;
                end
            end
            ST_ENV_MUL: begin
                cmd.env_mul = 1'b1;
                state_next  = ST_ENV_UPD;
            end
            ST_ENV_UPD: begin
                cmd.env_update = 1'b1;
                state_next     = ST_KNEE;
            end
            ST_KNEE: begin
                if (sts.env_over) begin
                    cmd.knee_mul = 1'b1;
                    state_next   = ST_DIVK_GO;
                end else begin
                    state_next   = ST_GAIN;
                end
            end
            ST_DIVK_GO: begin
                cmd.divk_start = 1'b1;
                state_next     = ST_DIVK_RUN;
            end
            ST_DIVK_RUN: begin
                if (sts.div_done) begin
                    state_next = ST_DIVG_GO;
                end
            end
            ST_DIVG_GO: begin
                cmd.divg_start = 1'b1;
                state_next     = ST_DIVG_RUN;
            end
            ST_DIVG_RUN: begin
                if (sts.div_done) begin
                    state_next = ST_GAIN;
                end
            end
            ST_GAIN: begin
                cmd.gain_load = 1'b1;
                state_next    = ST_SCALE;
            end
            ST_SCALE: begin
                cmd.scale_step = 1'b1;
                if (sts.lane_last) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                if (sts.out_free) begin
                    cmd.result_load = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

endmodule

>>> rtl/skpl_dp.sv
// Datapath of the peak limiter: frame store, peak scan, envelope and knee products and
// lane scaling on one shared multiplier, knee and gain divisions, and result register.
// Depends on skpl_pkg and skpl_div.
module skpl_dp (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  skpl_pkg::ctrl_cmd_t  cmd,
    output skpl_pkg::dp_sts_t    sts,
    input  skpl_pkg::cfg_t       cfg,
    input  skpl_pkg::in_item_t   s_payload,
    input  logic                 m_ready,
    output logic                 m_valid,
    output skpl_pkg::out_item_t  m_payload
);
    import skpl_pkg::*;

    sample_t              smp_reg [MAX_CHANNELS];
    sample_t              smp_next[MAX_CHANNELS];
    sample_t              res_reg [MAX_CHANNELS];
    sample_t              res_next[MAX_CHANNELS];
    logic                 blk_reg, blk_next;
    logic [COUNT_W-1:0]   nch_reg, nch_next;
    logic [LANE_W-1:0]    lane_reg, lane_next;
    logic [PEAK_W-1:0]    peak_reg, peak_next;
    logic [ENV_W-1:0]     env_reg, env_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic [GAIN_W-1:0]    gain_reg, gain_next;
    out_item_t            out_reg, out_next;
    logic                 m_valid_reg, m_valid_next;

    sample_t              in_smp[MAX_CHANNELS];
    sample_t              cur_smp;
    logic                 lane_active;
    logic [PEAK_W-1:0]    cur_abs;
    logic [COEFF_W-1:0]   coeff;
    logic [COEFF_W:0]     coeff_rest;
    logic [ENV_W-1:0]     over;
    logic [DIV_DEN_W-1:0] knee_den;
    logic [ENV_W-1:0]     comp;
    logic [DIV_NUM_W-1:0] numk;
    logic [DIV_NUM_W-1:0] numg;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_DEN_W-1:0] div_den;
    logic                 div_start;
    logic                 div_done;
    logic [DIV_DEN_W-1:0] quot;
    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] prod_full;
    logic signed [PROD_W-1:0] rnd;
    logic signed [PROD_W-1:0] shifted;
    sample_t              scaled;
    logic [DIV_NUM_W:0]   env_acc;
    logic                 env_over;
    logic                 unity;

    assign in_smp[0] = s_payload.sample_0;
    assign in_smp[1] = s_payload.sample_1;
    assign in_smp[2] = s_payload.sample_2;
    assign in_smp[3] = s_payload.sample_3;
    assign in_smp[4] = s_payload.sample_4;
    assign in_smp[5] = s_payload.sample_5;
    assign in_smp[6] = s_payload.sample_6;
    assign in_smp[7] = s_payload.sample_7;

    assign cur_smp     = smp_reg[lane_reg];
    assign lane_active = ({1'b0, lane_reg} < nch_reg);
    assign cur_abs     = cur_smp[SAMPLE_BITS-1] ? (PEAK_W'(0) - {cur_smp[SAMPLE_BITS-1], cur_smp})
                                                : {1'b0, cur_smp};

    // Attack on a rising peak, release otherwise.
    assign coeff      = (peak_reg > {1'b0, env_reg}) ? cfg.attack_coeff : cfg.release_coeff;
    assign coeff_rest = {1'b1, {COEFF_W{1'b0}}} - {1'b0, coeff};

    assign env_over = (env_reg > {1'b0, cfg.knee_start});
    assign over     = env_reg - {1'b0, cfg.knee_start};
    assign knee_den = {1'b0, cfg.knee_width} + over;
    assign comp     = {1'b0, cfg.knee_start} + quot;
    assign numk     = prod_reg[DIV_NUM_W-1:0] + {17'd0, knee_den[DIV_DEN_W-1:1]};
    assign numg     = {1'b0, comp, 15'd0} + {17'd0, env_reg[ENV_W-1:1]};

    assign div_start = cmd.divk_start | cmd.divg_start;
    assign div_num   = cmd.divg_start ? numg : numk;
    assign div_den   = cmd.divg_start ? env_reg : knee_den;

    skpl_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quot    (quot)
    );

    // One multiplier, its operands chosen by the current step.
    always_comb begin
        if (cmd.env_mul) begin
            mul_a = {2'b00, coeff};
            mul_b = {2'b00, env_reg};
        end else if (cmd.env_update) begin
            mul_a = {1'b0, coeff_rest};
            mul_b = {1'b0, peak_reg};
        end else if (cmd.knee_mul) begin
            mul_a = {2'b00, over};
            mul_b = {3'b000, cfg.knee_width};
        end else begin
            mul_a = {{(MUL_W-SAMPLE_BITS){cur_smp[SAMPLE_BITS-1]}}, cur_smp};
            mul_b = {2'b00, gain_reg};
        end
    end

    assign prod_full = mul_a * mul_b;
    assign env_acc   = {1'b0, prod_reg[DIV_NUM_W-1:0]} + {1'b0, prod_full[DIV_NUM_W-1:0]}
                       + (DIV_NUM_W+1)'(32768);

    // Round half up and saturate to the sample range.
    assign rnd     = prod_full + PROD_W'(16384);
    assign shifted = rnd >>> 15;
    always_comb begin
        if (shifted > PROD_W'(32767)) begin
            scaled = 16'sh7FFF;
        end else if (shifted < -PROD_W'(32768)) begin
            scaled = 16'sh8000;
        end else begin
            scaled = shifted[SAMPLE_BITS-1:0];
        end
    end

    assign unity = (gain_reg == GAIN_ONE);

    always_comb begin
        smp_next     = smp_reg;
        res_next     = res_reg;
        blk_next     = blk_reg;
        nch_next     = nch_reg;
        lane_next    = lane_reg;
        peak_next    = peak_reg;
        env_next     = env_reg;
        prod_next    = prod_reg;
        gain_next    = gain_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        if (cmd.load_item) begin
            smp_next  = in_smp;
            blk_next  = s_payload.block_end;
            lane_next = '0;
            peak_next = '0;
            if (cfg.channel_count == '0) begin
                nch_next = COUNT_W'(1);
            end else if (cfg.channel_count > COUNT_W'(MAX_CHANNELS)) begin
                nch_next = COUNT_W'(MAX_CHANNELS);
            end else begin
                nch_next = cfg.channel_count;
            end
        end

        if (cmd.peak_step) begin
            lane_next = lane_reg + 1'b1;
            if (lane_active && (cur_abs > peak_reg)) begin
                peak_next = cur_abs;
            end
        end

        if (cmd.env_mul || cmd.knee_mul) begin
            prod_next = prod_full;
        end

        if (cmd.env_update) begin
            env_next = env_acc[ENV_W+15:16];
        end

        if (cmd.gain_load) begin
            lane_next = '0;
            if (env_over && (quot < GAIN_UNITY_MIN)) begin
                gain_next = quot;
            end else begin
                gain_next = GAIN_ONE;
            end
        end

        if (cmd.scale_step) begin
            lane_next = lane_reg + 1'b1;
            if (!lane_active) begin
                res_next[lane_reg] = '0;
            end else if (unity) begin
                res_next[lane_reg] = cur_smp;
            end else begin
                res_next[lane_reg] = scaled;
            end
        end

        if (cmd.result_load) begin
            out_next.out_0         = res_reg[0];
            out_next.out_1         = res_reg[1];
            out_next.out_2         = res_reg[2];
            out_next.out_3         = res_reg[3];
            out_next.out_4         = res_reg[4];
            out_next.out_5         = res_reg[5];
            out_next.out_6         = res_reg[6];
            out_next.out_7         = res_reg[7];
            out_next.applied_gain  = gain_reg;
            out_next.block_end_out = blk_reg;
            m_valid_next           = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            env_reg     <= '0;
            m_valid_reg <= 1'b0;
            lane_reg    <= '0;
        end else begin
            env_reg     <= env_next;
            m_valid_reg <= m_valid_next;
            lane_reg    <= lane_next;
        end
        smp_reg  <= smp_next;
        res_reg  <= res_next;
        blk_reg  <= blk_next;
        nch_reg  <= nch_next;
        peak_reg <= peak_next;
        prod_reg <= prod_next;
        gain_reg <= gain_next;
        out_reg  <= out_next;
    end

    assign sts.lane_last = (lane_reg == LANE_W'(MAX_CHANNELS - 1));
    assign sts.env_over  = env_over;
    assign sts.div_done  = div_done;
    assign sts.out_free  = !m_valid_reg || m_ready;

    assign m_valid   = m_valid_reg;
    assign m_payload = out_reg;

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the soft-knee peak limiter: a frame scoreboard with its own
// envelope and gain arithmetic, directed and random frames, and random back-pressure.
// Depends on skpl_pkg and soft_knee_peak_limiter.
module tb;

    import skpl_pkg::*;

    // Margin allowed after the last result, longer than the slowest frame.
    localparam int SETTLE_CYCLES  = 84;
    // No request on any channel for this long means the block has hung.
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_PHASES  = 9;
    localparam int PHASE_FRAMES   = 105;
    // Mismatch lines beyond this are counted but not printed.
    localparam int MAX_REPORTS    = 40;

    localparam sample_t SAMPLE_HI = sample_t'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam sample_t SAMPLE_LO = sample_t'(-(1 << (SAMPLE_BITS - 1)));

    // Receiver behaviour, picked anew at random for each stretch of the run.
    typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_LONG} rx_mode_e;
    // Sample content of one burst of frames.
    typedef enum {STYLE_LOUD, STYLE_QUIET, STYLE_ANY, STYLE_EDGE} frame_style_e;

    // The scoreboard keeps its own copy of the registers and of the envelope, and
    // predicts each limited frame at the moment its request is accepted. Results
    // come back strictly in order, so one queue is enough.
    class limiter_scoreboard;
        cfg_t               regs;
        logic [ENV_W-1:0]   env_level;
        out_item_t          limited_frames_q[$];
        int unsigned        results_seen;
        int                 errors;

        function new();
            regs.channel_count = RST_CHANNEL_COUNT;
            regs.attack_coeff  = RST_ATTACK_COEFF;
            regs.release_coeff = RST_RELEASE_COEFF;
            regs.knee_start    = RST_KNEE_START;
            regs.knee_width    = RST_KNEE_WIDTH;
            env_level    = '0;
            results_seen = 0;
            errors       = 0;
        endfunction

        task report(string msg);
            if (errors < MAX_REPORTS) begin
                $display("MISMATCH: %s", msg);
            end
            errors++;
        endtask

        function int pending();
            return limited_frames_q.size();
        endfunction

        // Spare indexes are ignored, as the block does.
        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_CHANNEL_COUNT: regs.channel_count = data[COUNT_W-1:0];
                REG_ATTACK_COEFF:  regs.attack_coeff  = data[COEFF_W-1:0];
                REG_RELEASE_COEFF: regs.release_coeff = data[COEFF_W-1:0];
                REG_KNEE_START:    regs.knee_start    = data[LEVEL_W-1:0];
                REG_KNEE_WIDTH:    regs.knee_width    = data[LEVEL_W-1:0];
                default: ;
            endcase
        endfunction

        static function void out_lanes(out_item_t r, output sample_t l[MAX_CHANNELS]);
            l[0] = r.out_0; l[1] = r.out_1; l[2] = r.out_2; l[3] = r.out_3;
            l[4] = r.out_4; l[5] = r.out_5; l[6] = r.out_6; l[7] = r.out_7;
        endfunction

        function void note_frame(in_item_t f);
            sample_t            lane [MAX_CHANNELS];
            sample_t            res  [MAX_CHANNELS];
            int unsigned        used, peak, mag;
            longint unsigned    coeff, env_next, over, den, comp, ratio, ks, kw;
            longint             prod, q;
            logic [GAIN_W-1:0]  gain;
            out_item_t          want;

            lane[0] = f.sample_0; lane[1] = f.sample_1; lane[2] = f.sample_2;
            lane[3] = f.sample_3; lane[4] = f.sample_4; lane[5] = f.sample_5;
            lane[6] = f.sample_6; lane[7] = f.sample_7;

            // A count of zero means one lane; anything beyond the lane count saturates.
            used = regs.channel_count;
            if (used == 0) begin
                used = 1;
            end else if (used > MAX_CHANNELS) begin
                used = MAX_CHANNELS;
            end

            // The most negative sample keeps its full magnitude in the peak.
            peak = 0;
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                if (i < used) begin
                    mag = (lane[i] < 0) ? -int'(lane[i]) : int'(lane[i]);
                    if (mag > peak) begin
                        peak = mag;
                    end
                end
            end

            // One-pole follower: attack on a rising peak, release otherwise.
            coeff    = (peak > env_level) ? regs.attack_coeff : regs.release_coeff;
            env_next = (coeff * env_level + (65536 - coeff) * peak + 32768) >> 16;
            env_level = env_next[ENV_W-1:0];

            // Above the knee start the level is squeezed towards knee_start + knee_width;
            // with a zero knee width the curve becomes a hard knee.
            gain = GAIN_ONE;
            ks   = regs.knee_start;
            kw   = regs.knee_width;
            if (env_next > ks) begin
                over  = env_next - ks;
                den   = kw + over;
                comp  = ks + (over * kw + den / 2) / den;
                ratio = ((comp << 15) + env_next / 2) / env_next;
                if (ratio > GAIN_ONE) begin
                    ratio = GAIN_ONE;
                end
                gain = ratio[GAIN_W-1:0];
            end
            if (gain >= GAIN_UNITY_MIN) begin
                gain = GAIN_ONE;
            end

            // Scaling rounds half up and saturates; unused lanes are zero.
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                res[i] = '0;
                if (i < used) begin
                    if (gain == GAIN_ONE) begin
                        res[i] = lane[i];
                    end else begin
                        prod = longint'(lane[i]) * longint'(gain) + 16384;
                        q    = prod >>> 15;
                        if (q > SAMPLE_HI) begin
                            q = SAMPLE_HI;
                        end
                        if (q < SAMPLE_LO) begin
                            q = SAMPLE_LO;
                        end
                        res[i] = q[SAMPLE_BITS-1:0];
                    end
                end
            end

            want.out_0 = res[0]; want.out_1 = res[1]; want.out_2 = res[2];
            want.out_3 = res[3]; want.out_4 = res[4]; want.out_5 = res[5];
            want.out_6 = res[6]; want.out_7 = res[7];
            want.applied_gain  = gain;
            want.block_end_out = f.block_end;
            limited_frames_q.push_back(want);
        endfunction

        task check_limited_frame(out_item_t got);
            out_item_t  want;
            sample_t    got_l  [MAX_CHANNELS];
            sample_t    want_l [MAX_CHANNELS];

            results_seen++;
            if (limited_frames_q.size() == 0) begin
                report($sformatf("result %0d arrived with no frame outstanding", results_seen));
                return;
            end
            want = limited_frames_q.pop_front();
            out_lanes(got, got_l);
            out_lanes(want, want_l);
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                if (got_l[i] !== want_l[i]) begin
                    report($sformatf("result %0d: out_%0d is %0d, expected %0d",
                                     results_seen, i, got_l[i], want_l[i]));
                end
            end
            if (got.applied_gain !== want.applied_gain) begin
                report($sformatf("result %0d: applied_gain is %0d, expected %0d",
                                 results_seen, got.applied_gain, want.applied_gain));
            end
            if (got.block_end_out !== want.block_end_out) begin
                report($sformatf("result %0d: block_end_out is %0b, expected %0b",
                                 results_seen, got.block_end_out, want.block_end_out));
            end
        endtask
    endclass

    logic                       aclk;
    logic                       aresetn;
    logic                       s_valid;
    logic                       s_ready;
    in_item_t                   s_payload;
    logic                       m_valid;
    logic                       m_ready;
    out_item_t                  m_payload;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_INDEX_W-1:0]     cfg_index;
    logic [CFG_DATA_W-1:0]      cfg_data;

    limiter_scoreboard sb = new();

    int unsigned    quiet_cycles = 0;
    rx_mode_e       rx_mode = RX_OPEN;
    int unsigned    rx_hold = 0;
    int unsigned    rx_tick = 0;

    soft_knee_peak_limiter u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 8 ns period, first rising edge at 4 ns.
    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    // Every request is observed at the rising edge on the values that were settled before it,
    // so the drivers' nonblocking updates at the same edge cannot disturb what is seen here.
    // A register write is noted before a frame accepted at the same edge, and a result is
    // checked after it; the result then always belongs to an older frame.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                sb.write_reg(cfg_index, cfg_data);
            end
            if (s_valid && s_ready) begin
                sb.note_frame(s_payload);
            end
            if (m_valid && m_ready) begin
                sb.check_limited_frame(m_payload);
            end
        end
    end

    // The watchdog is restarted by any request on any channel. The longest honest silence
    // is a slow frame behind a long output stall and a long sender gap.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // The receiver changes its habits at regular intervals: always ready, a coin toss per cycle,
    // ready one cycle in four, or mostly ready with the odd stall of random length. The
    // open mode gives stretches where the output never waits.
    always @(posedge aclk) begin
        if (rx_tick % 256 == 0) begin
            rx_mode = rx_mode_e'($urandom_range(0, 3));
        end
        rx_tick++;
        if (rx_hold != 0) begin
            rx_hold--;
            m_ready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_OPEN:   m_ready <= 1'b1;
                RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: m_ready <= (rx_tick % 4 == 0);
                default: begin
                    if ($urandom_range(0, 15) == 0) begin
                        rx_hold = $urandom_range(10, 60);
                        m_ready <= 1'b0;
                    end else begin
                        m_ready <= 1'b1;
                    end
                end
            endcase
        end
    end

    // Holds a frame on the input until the block takes it. Returns at the accepting edge
    // with valid still high, so a following frame can go straight out behind it.
    task send_frame(in_item_t f);
        s_payload <= f;
        s_valid   <= 1'b1;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
    endtask

    // A gap between bursts; a zero-length gap leaves valid high.
    task pause(int unsigned cycles);
        if (cycles != 0) begin
            s_valid <= 1'b0;
            repeat (cycles) @(posedge aclk);
        end
    endtask

    // Stops sending and waits until every predicted frame has come back, which leaves the
    // block idle since each frame yields exactly one result.
    task drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) begin
            @(posedge aclk);
        end
    endtask

    // Valid is left high so that back-to-back writes need no second update in one step.
    task put_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
    endtask

    // Writes every register once the block has gone idle. The bits above each field's
    // width carry random junk, and now and then a spare index is written as well.
    task load_setting(cfg_t c);
        logic [CFG_DATA_W-1:0] junk;

        junk = CFG_DATA_W'($urandom);
        drain();
        put_reg(REG_CHANNEL_COUNT, {junk[CFG_DATA_W-1:COUNT_W], c.channel_count});
        put_reg(REG_ATTACK_COEFF, c.attack_coeff);
        put_reg(REG_RELEASE_COEFF, c.release_coeff);
        put_reg(REG_KNEE_START, {junk[3], c.knee_start});
        if ($urandom_range(0, 3) == 0) begin
            put_reg(REG_KNEE_WIDTH + CFG_INDEX_W'($urandom_range(1, 3)), junk);
        end
        put_reg(REG_KNEE_WIDTH, {junk[2], c.knee_width});
        cfg_valid <= 1'b0;
    endtask

    function automatic in_item_t frame_of(sample_t l[MAX_CHANNELS], logic be);
        in_item_t f;

        f.sample_0 = l[0]; f.sample_1 = l[1]; f.sample_2 = l[2]; f.sample_3 = l[3];
        f.sample_4 = l[4]; f.sample_5 = l[5]; f.sample_6 = l[6]; f.sample_7 = l[7];
        f.block_end = be;
        return f;
    endfunction

    function automatic in_item_t uniform_frame(sample_t v, logic be);
        sample_t l [MAX_CHANNELS];

        foreach (l[i]) begin
            l[i] = v;
        end
        return frame_of(l, be);
    endfunction

    // Coefficients: the two extremes, anything at all, or the slow end where real
    // time constants of tens to thousands of samples live.
    function automatic logic [COEFF_W-1:0] pick_coeff(int unsigned slow_floor);
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return '1;
            2:       return COEFF_W'($urandom);
            default: return COEFF_W'($urandom_range(slow_floor, 65535));
        endcase
    endfunction

    function automatic cfg_t random_setting();
        cfg_t c;

        c.channel_count = COUNT_W'($urandom_range(0, 15));
        c.attack_coeff  = pick_coeff(60000);
        c.release_coeff = pick_coeff(64000);
        case ($urandom_range(0, 4))
            0:       c.knee_start = '0;
            1:       c.knee_start = '1;
            2:       c.knee_start = LEVEL_W'($urandom);
            default: c.knee_start = LEVEL_W'($urandom_range(4000, 31000));
        endcase
        case ($urandom_range(0, 5))
            0:       c.knee_width = '0;
            1:       c.knee_width = LEVEL_W'(1);
            2:       c.knee_width = '1;
            3:       c.knee_width = LEVEL_W'($urandom);
            default: c.knee_width = LEVEL_W'($urandom_range(200, 8000));
        endcase
        return c;
    endfunction

    // Loud bursts push the envelope over the knee, quiet ones let it release; the edge
    // style keeps hitting full scale, the most negative value and the smallest steps.
    function automatic sample_t random_sample(frame_style_e style);
        int mag;

        case (style)
            STYLE_LOUD: begin
                mag = $urandom_range(20000, 32768);
                if ($urandom_range(0, 1) != 0) begin
                    return sample_t'(-mag);
                end
                return (mag > SAMPLE_HI) ? SAMPLE_HI : sample_t'(mag);
            end
            STYLE_QUIET: return sample_t'(int'($urandom_range(0, 4000)) - 2000);
            STYLE_ANY:   return sample_t'($urandom);
            default: begin
                case ($urandom_range(0, 4))
                    0:       return '0;
                    1:       return SAMPLE_HI;
                    2:       return SAMPLE_LO;
                    3:       return sample_t'(-1);
                    default: return sample_t'(1);
                endcase
            end
        endcase
    endfunction

    function automatic in_item_t random_frame(frame_style_e style);
        sample_t l [MAX_CHANNELS];

        foreach (l[i]) begin
            l[i] = random_sample(style);
        end
        return frame_of(l, 1'($urandom_range(0, 1)));
    endfunction

    initial begin
        in_item_t       d;
        sample_t        mix [MAX_CHANNELS];
        int unsigned    sent, burst, gap, pick;
        frame_style_e   style;

        // Every input is known from time zero; reset is applied once only.
        s_valid   <= 1'b0;
        s_payload <= '0;
        m_ready   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_CHANNEL_COUNT;
        cfg_data  <= '0;
        aresetn   <= 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // A lane mix that exercises rounding in both directions and saturation.
        mix = '{SAMPLE_HI, SAMPLE_LO, 1, -1, 16384, -16385, 12345, -7};

        // Reset setting, two lanes: silence, both full-scale extremes, and loud samples
        // sitting only in the unused lanes, which must neither enter the peak nor pass.
        send_frame(uniform_frame('0, 1'b0));
        send_frame(uniform_frame(SAMPLE_HI, 1'b1));
        send_frame(uniform_frame(SAMPLE_LO, 1'b0));
        d = uniform_frame(SAMPLE_LO, 1'b1);
        d.sample_0 = 100;
        d.sample_1 = -100;
        send_frame(d);
        d = uniform_frame(16'sh5555, 1'b0);
        d.sample_1 = 16'shAAAA;
        d.sample_3 = 16'shAAAA;
        d.sample_5 = 16'shAAAA;
        d.sample_7 = 16'shAAAA;
        send_frame(d);

        // Channel count zero acts as one lane. Instant attack, frozen release, and a hard
        // knee at zero, which drives the gain to nothing once anything is heard.
        load_setting('{channel_count: '0, attack_coeff: '0, release_coeff: '1,
                       knee_start: '0, knee_width: '0});
        d = uniform_frame(SAMPLE_LO, 1'b0);
        d.sample_0 = SAMPLE_HI;
        send_frame(d);
        send_frame(uniform_frame(SAMPLE_LO, 1'b1));
        d = uniform_frame(SAMPLE_HI, 1'b0);
        d.sample_0 = 1;
        send_frame(d);
        send_frame(uniform_frame('0, 1'b1));

        // A count above the lane total saturates to eight. Both coefficients zero make the
        // envelope follow the peak exactly, with the narrowest soft knee at mid scale.
        load_setting('{channel_count: '1, attack_coeff: '0, release_coeff: '0,
                       knee_start: LEVEL_W'(16384), knee_width: LEVEL_W'(1)});
        send_frame(uniform_frame(SAMPLE_LO, 1'b0));
        send_frame(frame_of(mix, 1'b1));
        send_frame(uniform_frame('0, 1'b0));

        // Frozen envelope and the highest knee: the gain stays at unity.
        load_setting('{channel_count: COUNT_W'(MAX_CHANNELS), attack_coeff: '1,
                       release_coeff: '1, knee_start: '1, knee_width: '1});
        send_frame(uniform_frame(SAMPLE_LO, 1'b1));
        send_frame(frame_of(mix, 1'b0));

        // Reset knee with an instant attack, so full scale lands well above the knee,
        // followed by a release back towards unity.
        load_setting('{channel_count: COUNT_W'(7), attack_coeff: '0,
                       release_coeff: COEFF_W'(60000), knee_start: RST_KNEE_START,
                       knee_width: RST_KNEE_WIDTH});
        send_frame(uniform_frame(SAMPLE_LO, 1'b0));
        send_frame(frame_of(mix, 1'b1));
        send_frame(uniform_frame(SAMPLE_HI, 1'b0));
        send_frame(uniform_frame('0, 1'b1));

        // Random part: one setting per phase, frames in bursts of one style each, and gaps
        // from none up to longer than the slowest frame so they land on every stage.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            load_setting(random_setting());
            sent = 0;
            while (sent < PHASE_FRAMES) begin
                burst = $urandom_range(1, 16);
                pick  = $urandom_range(0, 99);
                style = (pick < 40) ? STYLE_LOUD  :
                        (pick < 60) ? STYLE_QUIET :
                        (pick < 85) ? STYLE_ANY   : STYLE_EDGE;
                repeat (burst) begin
                    send_frame(random_frame(style));
                    sent++;
                end
                pick = $urandom_range(0, 99);
                gap  = (pick < 30) ? 0 :
                       (pick < 70) ? $urandom_range(1, 8) : $urandom_range(9, 60);
                pause(gap);
            end
        end

        // Wait for the last results, then allow for anything the block might still emit.
        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (sb.pending() != 0) begin
            sb.report($sformatf("%0d frames never returned", sb.pending()));
        end
        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
